// ===== sv/pil_pkg.sv =====
// ----------------------------------------------------------------------------
// Positional insert list package
// Shared widths, operation codes and the command and status structs that
// join the controller and the datapath.
// ----------------------------------------------------------------------------
package pil_pkg;

   // Default sizes for the top-level parameters.
   localparam int CAPACITY_DEF    = 16;
   localparam int VALUE_WIDTH_DEF = 32;

   // Fixed field widths of the stream channels.
   localparam int FUNC_W      = 2;
   localparam int POS_W       = 16;
   localparam int VAL_W       = 32;
   localparam int ELEM_W      = 32;
   localparam int LEN_W       = 5;
   localparam int MAG_W       = POS_W + 1;
   localparam int REQ_TDATA_W = 48;
   localparam int RSP_TDATA_W = 40;

   // Request operation codes carried on req_tuser.
   typedef logic [FUNC_W-1:0] func_type;
   localparam func_type FUNC_APPEND = 2'd0;
   localparam func_type FUNC_REMOVE = 2'd1;
   localparam func_type FUNC_INSERT = 2'd2;
   localparam func_type FUNC_DUMP   = 2'd3;

   // Datapath operations on the cell row.
   typedef logic [1:0] dp_op_type;
   localparam dp_op_type DP_OP_HOLD   = 2'd0;
   localparam dp_op_type DP_OP_INSERT = 2'd1;
   localparam dp_op_type DP_OP_REMOVE = 2'd2;
   localparam dp_op_type DP_OP_ROTATE = 2'd3;

   typedef struct packed {
      dp_op_type op;            // change applied to the cell row and count
      logic      tail_sel;      // insert at the tail instead of at the position
      logic      dump_start;    // clear the dump counter
      logic      load_rsp;      // load the result register
      logic      rsp_from_cell; // result element comes from the head cell
      logic      rsp_last;      // result closes the request
      logic      rsp_ok;        // result ok flag
   } dp_cmd_type;

   typedef struct packed {
      logic empty;
      logic full;
      logic mag_zero;   // insert position has zero magnitude
      logic dump_last;  // head cell is the last element of the running dump
   } dp_stat_type;

endpackage

// ===== sv/positional_insert_list.sv =====
// ----------------------------------------------------------------------------
// Positional insert list
// Bounded ordered list of signed words with append, remove, insert and dump.
// ----------------------------------------------------------------------------
// The block keeps up to CAPACITY signed words in order in a row of shift
// cells. For append, remove-last and insert-at-position the request is
// accepted, the cell row shifts in that same edge, and exactly one response
// (tlast high, element zero) is written to the response register. Insert
// uses the magnitude of the position; zero is a no-op, one is the head, and
// anything beyond the count appends. A dump sends one response per element,
// head first, with tlast on the final one; the elements are loaded one by
// one, paced by the single response register, while the list rotates once
// through the cell row and ends up unchanged. A dump of an empty list
// answers at once with one failed response. A new request is accepted
// whenever no dump is running and the response register is empty or being
// read in the same cycle, so a steady stream of non-dump requests runs at
// one request per cycle. Full and empty conditions do not stall; they are
// reported with ok low in the response.
// ----------------------------------------------------------------------------
module positional_insert_list #(
   parameter int CAPACITY    = pil_pkg::CAPACITY_DEF,
   parameter int VALUE_WIDTH = pil_pkg::VALUE_WIDTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // [15:0] position, [47:16] value
   input  logic [pil_pkg::REQ_TDATA_W-1:0]     req_tdata,
   // [1:0] func
   input  logic [pil_pkg::FUNC_W-1:0]          req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [31:0] element, [36:32] length, [39:37] zero
   output logic [pil_pkg::RSP_TDATA_W-1:0]     rsp_tdata,
   // done_res
   output logic                                rsp_tlast,
   // [0] ok
   output logic                                rsp_tuser
);

   localparam int POS_W  = pil_pkg::POS_W;
   localparam int VAL_W  = pil_pkg::VAL_W;
   localparam int ELEM_W = pil_pkg::ELEM_W;
   localparam int LEN_W  = pil_pkg::LEN_W;
   localparam int PAD_W  = pil_pkg::RSP_TDATA_W - ELEM_W - LEN_W;

   pil_pkg::dp_cmd_type  cmd;
   pil_pkg::dp_stat_type stat;

   logic signed [ELEM_W-1:0] rsp_element;
   logic        [LEN_W-1:0]  rsp_length;

   // Control: request decode, dump sequencing and response valid.
   pil_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_func   (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   // Cell row, count and response payload.
   pil_dp #(
      .CAPACITY    (CAPACITY),
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .req_position (req_tdata[POS_W-1:0]),
      .req_value    (req_tdata[POS_W+VAL_W-1:POS_W]),
      .cmd          (cmd),
      .stat         (stat),
      .rsp_element  (rsp_element),
      .rsp_last     (rsp_tlast),
      .rsp_ok       (rsp_tuser),
      .rsp_length   (rsp_length)
   );

   assign rsp_tdata = {{PAD_W{1'b0}}, rsp_length, rsp_element};

endmodule

// ===== sv/pil_ctrl.sv =====
// ----------------------------------------------------------------------------
// Positional insert list controller
// Decodes requests, sequences dumps and owns the result valid flag.
// ----------------------------------------------------------------------------
module pil_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  pil_pkg::func_type    req_func,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   input  pil_pkg::dp_stat_type stat,
   output pil_pkg::dp_cmd_type  cmd
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_DUMP = 1'b1;

   logic state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic slot_free;
   logic accept;

   // The result register can take a new result when it is empty or drains now.
   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE) && slot_free;
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      cmd          = '0;
      cmd.op       = pil_pkg::DP_OP_HOLD;
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd.rsp_last = 1'b1;
               cmd.load_rsp = 1'b1;
               unique case (req_func)
                  pil_pkg::FUNC_APPEND: begin
                     cmd.tail_sel = 1'b1;
                     cmd.rsp_ok   = !stat.full;
                     if (!stat.full) begin
                        cmd.op = pil_pkg::DP_OP_INSERT;
                     end
                  end
                  pil_pkg::FUNC_REMOVE: begin
                     cmd.rsp_ok = !stat.empty;
                     if (!stat.empty) begin
                        cmd.op = pil_pkg::DP_OP_REMOVE;
                     end
                  end
                  pil_pkg::FUNC_INSERT: begin
                     cmd.rsp_ok = !stat.full && !stat.mag_zero;
                     if (!stat.full && !stat.mag_zero) begin
                        cmd.op = pil_pkg::DP_OP_INSERT;
                     end
                  end
                  pil_pkg::FUNC_DUMP: begin
                     // An empty list answers at once with a single failed result.
                     if (!stat.empty) begin
                        cmd.load_rsp   = 1'b0;
                        cmd.dump_start = 1'b1;
                        state_in       = ST_DUMP;
                     end
                  end
               endcase
            end
         end
         ST_DUMP: begin
            if (slot_free) begin
               cmd.op            = pil_pkg::DP_OP_ROTATE;
               cmd.load_rsp      = 1'b1;
               cmd.rsp_from_cell = 1'b1;
               cmd.rsp_last      = stat.dump_last;
               cmd.rsp_ok        = 1'b1;
               if (stat.dump_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
      endcase
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== sv/pil_dp.sv =====
// ----------------------------------------------------------------------------
// Positional insert list datapath
// Row of shift cells with the element count, dump counter and result register.
// ----------------------------------------------------------------------------
module pil_dp #(
   parameter int CAPACITY    = pil_pkg::CAPACITY_DEF,
   parameter int VALUE_WIDTH = pil_pkg::VALUE_WIDTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic signed [pil_pkg::POS_W-1:0]  req_position,
   input  logic signed [pil_pkg::VAL_W-1:0]  req_value,
   input  pil_pkg::dp_cmd_type               cmd,
   output pil_pkg::dp_stat_type              stat,
   output logic signed [pil_pkg::ELEM_W-1:0] rsp_element,
   output logic                              rsp_last,
   output logic                              rsp_ok,
   output logic        [pil_pkg::LEN_W-1:0]  rsp_length
);

   localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int MW    = pil_pkg::MAG_W;
   localparam int EW    = pil_pkg::ELEM_W;
   localparam int LW    = pil_pkg::LEN_W;

   logic [VALUE_WIDTH-1:0] cell_ff [CAPACITY];
   logic [VALUE_WIDTH-1:0] cell_in [CAPACITY];
   logic [VALUE_WIDTH-1:0] cell_up [CAPACITY];
   logic [VALUE_WIDTH-1:0] cell_dn [CAPACITY];
   logic [CNT_W-1:0]       count_ff, count_in;
   logic [IDX_W-1:0]       dump_ff, dump_in;
   logic [MW-1:0]          pos_ext, mag;
   logic [MW-1:0]          count_wide;
   logic [CNT_W-1:0]       pos_sel;
   logic [VALUE_WIDTH-1:0] new_val;
   logic [63:0]            val_wide;
   logic [63:0]            head_wide;

   logic signed [EW-1:0]   rsp_element_ff;
   logic                   rsp_last_ff;
   logic                   rsp_ok_ff;
   logic [LW-1:0]          rsp_length_ff;

   // Neighbor taps of each cell; the ends of the row see themselves.
   for (genvar g = 0; g < CAPACITY; g++) begin : g_tap
      if (g < CAPACITY - 1) begin : g_up
         assign cell_up[g] = cell_ff[g+1];
      end else begin : g_up_end
         assign cell_up[g] = cell_ff[g];
      end
      if (g > 0) begin : g_dn
         assign cell_dn[g] = cell_ff[g-1];
      end else begin : g_dn_end
         assign cell_dn[g] = cell_ff[g];
      end
   end

   // Magnitude of the insert position; the most negative code gives 32768.
   assign pos_ext    = {req_position[pil_pkg::POS_W-1], req_position};
   assign mag        = pos_ext[MW-1] ? (~pos_ext + MW'(1)) : pos_ext;
   assign count_wide = MW'(count_ff);

   // Slot that takes the new value: the tail for append or an out-of-range
   // position, else the position minus one.
   always_comb begin
      if (cmd.tail_sel || (mag > count_wide)) begin
         pos_sel = count_ff;
      end else begin
         pos_sel = mag[CNT_W-1:0] - CNT_W'(1);
      end
   end

   assign val_wide  = 64'(req_value);
   assign new_val   = val_wide[VALUE_WIDTH-1:0];
   assign head_wide = 64'(signed'(cell_ff[0]));

   always_comb begin
      for (int j = 0; j < CAPACITY; j++) begin
         cell_in[j] = cell_ff[j];
         unique case (cmd.op)
            pil_pkg::DP_OP_INSERT: begin
               if (CNT_W'(j) > pos_sel) begin
                  cell_in[j] = cell_dn[j];
               end else if (CNT_W'(j) == pos_sel) begin
                  cell_in[j] = new_val;
               end
            end
            pil_pkg::DP_OP_ROTATE: begin
               // Dump walks the list by rotating it; after count steps it is back.
               if (CNT_W'(j + 1) < count_ff) begin
                  cell_in[j] = cell_up[j];
               end else if (CNT_W'(j + 1) == count_ff) begin
                  cell_in[j] = cell_ff[0];
               end
            end
            pil_pkg::DP_OP_HOLD,
            pil_pkg::DP_OP_REMOVE: begin
            end
         endcase
      end
   end

   always_comb begin
      count_in = count_ff;
      dump_in  = dump_ff;
      unique case (cmd.op)
         pil_pkg::DP_OP_INSERT: count_in = count_ff + CNT_W'(1);
         pil_pkg::DP_OP_REMOVE: count_in = count_ff - CNT_W'(1);
         pil_pkg::DP_OP_ROTATE: dump_in  = dump_ff + IDX_W'(1);
         pil_pkg::DP_OP_HOLD: begin
         end
      endcase
      if (cmd.dump_start) begin
         dump_in = '0;
      end
   end

   assign stat.empty     = (count_ff == '0);
   assign stat.full      = (count_ff == CNT_W'(CAPACITY));
   assign stat.mag_zero  = (mag == '0);
   assign stat.dump_last = ((CNT_W'(dump_ff) + CNT_W'(1)) == count_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         dump_ff  <= '0;
      end else begin
         count_ff <= count_in;
         dump_ff  <= dump_in;
      end
   end

   always_ff @(posedge clock) begin
      cell_ff <= cell_in;
      if (cmd.load_rsp) begin
         rsp_element_ff <= cmd.rsp_from_cell ? head_wide[EW-1:0] : '0;
         rsp_last_ff    <= cmd.rsp_last;
         rsp_ok_ff      <= cmd.rsp_ok;
         rsp_length_ff  <= LW'(count_in);
      end
   end

   assign rsp_element = rsp_element_ff;
   assign rsp_last    = rsp_last_ff;
   assign rsp_ok      = rsp_ok_ff;
   assign rsp_length  = rsp_length_ff;

endmodule

// ===== sv/pil_chk.sv =====
// ----------------------------------------------------------------------------
// Positional insert list checker
// Port-level properties of the list block, bound to the top level.
// ----------------------------------------------------------------------------
module pil_chk (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tready,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [pil_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input logic                            rsp_tlast,
   input logic                            rsp_tuser
);

   // A held response keeps its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) &&
                                    $stable(rsp_tlast) && $stable(rsp_tuser))
      else $error("response changed while stalled");

   // A request is only taken when its response has somewhere to go.
   a_req_room: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !rsp_tvalid || rsp_tready)
      else $error("request ready while response register is blocked");

   // Only dump elements come without tlast, and those always have ok set.
   a_mid_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> rsp_tuser)
      else $error("dump element without ok");

   // Failed responses carry a zero element.
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata[pil_pkg::ELEM_W-1:0] == '0)
      else $error("failed response with nonzero element");

endmodule

bind positional_insert_list pil_chk u_pil_chk (.*);

// ===== verif/tb_positional_insert_list.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Positional insert list testbench
// Self-checking stream test: requests go through a queue-fed driver, and
// each response is checked field by field against a list tracked in the
// bench.
// ----------------------------------------------------------------------------
// A directed opening covers the corner cases: an empty list, a full list,
// positions of zero, one, beyond the count and the most negative position,
// and the extreme values. Random bursts follow. They fill the list to
// overflow, drain it to underflow, and mix every operation, with dumps in
// between. Both handshakes idle at random, and once in a while the sender
// holds off until every awaited response has come back.
// ----------------------------------------------------------------------------
module tb_positional_insert_list;

   localparam int LIST_DEPTH   = pil_pkg::CAPACITY_DEF;
   localparam int CLOCK_PERIOD = 8;
   localparam int CYCLE_LIMIT  = 1000000;
   localparam int TARGET_REQS  = 260;
   localparam int DRAIN_CYCLES = 40;

   localparam int POS_W       = pil_pkg::POS_W;
   localparam int VAL_W       = pil_pkg::VAL_W;
   localparam int ELEM_W      = pil_pkg::ELEM_W;
   localparam int LEN_W       = pil_pkg::LEN_W;
   localparam int REQ_TDATA_W = pil_pkg::REQ_TDATA_W;
   localparam int RSP_TDATA_W = pil_pkg::RSP_TDATA_W;

   // One request as it goes into the block.
   typedef struct {
      pil_pkg::func_type func;
      logic [POS_W-1:0]  position;
      logic [VAL_W-1:0]  value;
      bit                after_drain;   // send only once nothing is awaited
   } list_request_type;

   // One response as the block should send it.
   typedef struct {
      logic [ELEM_W-1:0] element;
      logic              last;
      logic              ok;
      logic [LEN_W-1:0]  length;
   } list_response_type;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_tvalid = 1'b0;
   logic                          req_tready;
   logic [REQ_TDATA_W-1:0]        req_tdata = '0;
   logic [pil_pkg::FUNC_W-1:0]    req_tuser = pil_pkg::FUNC_APPEND;
   logic                          rsp_tvalid;
   logic                          rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0]        rsp_tdata;
   logic                          rsp_tlast;
   logic                          rsp_tuser;

   list_request_type  request_backlog[$];
   list_response_type awaited_rsp[$];

   // The list as the block should hold it.
   logic [VAL_W-1:0] list_words[LIST_DEPTH];
   int unsigned      list_len = 0;

   // Length tracked while the stimulus is built, so positions can be aimed.
   int unsigned      plan_len = 0;

   int                mismatch_count = 0;
   int                cycle_count = 0;
   int                send_gap = 0;
   int                send_calm = 0;
   int                stall_left = 0;
   int                ready_calm = 0;
   list_request_type  drive_item;
   list_response_type got_rsp;

   positional_insert_list DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // List tracking
   // ------------------------------------------------------------------------

   // Places a word at the given slot and shifts the tail up. A slot past the
   // end lands at the tail. Returns zero when the list is already full.
   function automatic bit place_word(input int unsigned slot, input logic [VAL_W-1:0] word);
      int unsigned j;
      if (list_len >= LIST_DEPTH) return 1'b0;
      if (slot > list_len) slot = list_len;
      for (j = list_len; j > slot; j--) list_words[j] = list_words[j - 1];
      list_words[slot] = word;
      list_len++;
      return 1'b1;
   endfunction

   // Applies one accepted request to the tracked list and queues the
   // responses it should produce, in order.
   task automatic predict_list_op(input pil_pkg::func_type op,
                                  input logic [POS_W-1:0] pos,
                                  input logic [VAL_W-1:0] word);
      int unsigned       mag;
      int unsigned       j;
      bit                changed;
      list_response_type rsp;
      changed = 1'b0;
      case (op)
         pil_pkg::FUNC_APPEND: begin
            changed = place_word(list_len, word);
         end
         pil_pkg::FUNC_REMOVE: begin
            if (list_len > 0) begin
               list_len--;
               changed = 1'b1;
            end
         end
         pil_pkg::FUNC_INSERT: begin
            // Magnitude of a 16-bit signed position; the most negative one
            // gives 32768, which always lands at the tail.
            mag = pos[POS_W-1] ? 65536 - int'(pos) : int'(pos);
            if (mag != 0) changed = place_word((mag > list_len) ? list_len : mag - 1, word);
         end
         default: begin
            // A dump sends every element head first; an empty list gets one
            // failed response instead.
            if (list_len == 0) begin
               rsp = '{element: '0, last: 1'b1, ok: 1'b0, length: '0};
               awaited_rsp.push_back(rsp);
            end else begin
               for (j = 0; j < list_len; j++) begin
                  rsp = '{element: list_words[j], last: (j + 1 == list_len), ok: 1'b1,
                          length: LEN_W'(list_len)};
                  awaited_rsp.push_back(rsp);
               end
            end
            return;
         end
      endcase
      rsp = '{element: '0, last: 1'b1, ok: changed, length: LEN_W'(list_len)};
      awaited_rsp.push_back(rsp);
   endtask

   // ------------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------------

   function automatic int idle_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [VAL_W-1:0] pick_value();
      int r;
      r = $urandom_range(0, 99);
      if (r < 8)  return 32'h7fff_ffff;
      if (r < 16) return 32'h8000_0000;
      if (r < 20) return '0;
      if (r < 24) return '1;
      return $urandom();
   endfunction

   // Mostly positions inside or just past the list, either sign; some zero,
   // some anywhere in the 16-bit range, and now and then the most negative.
   function automatic logic [POS_W-1:0] pick_position();
      int          r;
      logic [POS_W-1:0] mag;
      r = $urandom_range(0, 99);
      if (r < 10) return '0;
      if (r < 25) return POS_W'($urandom());
      if (r < 30) return 16'h8000;
      mag = POS_W'($urandom_range(1, plan_len + 2));
      return $urandom_range(0, 1) ? -mag : mag;
   endfunction

   // Queues one request and keeps the planning length in step with it.
   task automatic queue_request(input pil_pkg::func_type op, input logic [POS_W-1:0] pos,
                                input logic [VAL_W-1:0] word, input bit hold = 1'b0);
      list_request_type item;
      item = '{func: op, position: pos, value: word, after_drain: hold};
      request_backlog.push_back(item);
      case (op)
         pil_pkg::FUNC_APPEND: if (plan_len < LIST_DEPTH) plan_len++;
         pil_pkg::FUNC_REMOVE: if (plan_len > 0) plan_len--;
         pil_pkg::FUNC_INSERT: if (pos != 0 && plan_len < LIST_DEPTH) plan_len++;
         default: ;
      endcase
   endtask

   task automatic queue_random_op(input bit hold = 1'b0);
      int r;
      r = $urandom_range(0, 99);
      if (r < 30)
         queue_request(pil_pkg::FUNC_APPEND, POS_W'($urandom()), pick_value(), hold);
      else if (r < 55)
         queue_request(pil_pkg::FUNC_REMOVE, POS_W'($urandom()), $urandom(), hold);
      else if (r < 90)
         queue_request(pil_pkg::FUNC_INSERT, pick_position(), pick_value(), hold);
      else
         queue_request(pil_pkg::FUNC_DUMP, POS_W'($urandom()), $urandom(), hold);
   endtask

   // Fills the list past full, with appends and inserts mixed.
   task automatic queue_fill_burst();
      int extra;
      while (plan_len < LIST_DEPTH) begin
         if ($urandom_range(0, 1))
            queue_request(pil_pkg::FUNC_APPEND, POS_W'($urandom()), pick_value());
         else
            queue_request(pil_pkg::FUNC_INSERT, pick_position() | 16'h0001, pick_value());
      end
      for (extra = $urandom_range(1, 2); extra > 0; extra--) begin
         if ($urandom_range(0, 1))
            queue_request(pil_pkg::FUNC_APPEND, POS_W'($urandom()), pick_value());
         else
            queue_request(pil_pkg::FUNC_INSERT, pick_position(), pick_value());
      end
   endtask

   // Removes down to empty and then a little beyond.
   task automatic queue_drain_burst();
      int extra;
      while (plan_len > 0)
         queue_request(pil_pkg::FUNC_REMOVE, POS_W'($urandom()), $urandom());
      for (extra = $urandom_range(1, 2); extra > 0; extra--)
         queue_request(pil_pkg::FUNC_REMOVE, POS_W'($urandom()), $urandom());
   endtask

   // ------------------------------------------------------------------------
   // Mismatch reporting
   // ------------------------------------------------------------------------

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      mismatch_count++;
      if (mismatch_count <= 50)
         $display("ERROR cycle %0d: %s: got %0h, expected %0h", cycle_count, what, got, want);
   endtask

   // ------------------------------------------------------------------------
   // Request driver
   // ------------------------------------------------------------------------
   // The driver looks at the handshake as it stood just before this edge.
   // Once the current request has gone (or none is up), it either idles for
   // the chosen gap or puts up the next request from the backlog. A request
   // marked to follow a drain waits until nothing is in flight and no
   // response is awaited; with no request valid, none is taken at this edge,
   // so an empty awaited queue seen here means nothing is outstanding.
   always @(posedge clock) begin
      if (!reset && (!req_tvalid || req_tready)) begin
         if (send_gap > 0) begin
            send_gap--;
            req_tvalid <= 1'b0;
         end else if (request_backlog.size() > 0 &&
                      (!request_backlog[0].after_drain ||
                       (!req_tvalid && awaited_rsp.size() == 0))) begin
            drive_item = request_backlog.pop_front();
            req_tvalid <= 1'b1;
            req_tuser  <= drive_item.func;
            req_tdata  <= {drive_item.value, drive_item.position};
            // Calm stretches send back to back; otherwise pick a gap.
            if (send_calm > 0) begin
               send_calm--;
               send_gap = 0;
            end else if ($urandom_range(0, 99) < 8) begin
               send_calm = $urandom_range(10, 40);
               send_gap  = 0;
            end else begin
               send_gap = idle_length();
            end
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Every accepted request updates the tracked list right away, so the
   // awaited responses stay in the order the block must send them.
   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready)
         predict_list_op(pil_pkg::func_type'(req_tuser), req_tdata[POS_W-1:0],
                         req_tdata[POS_W +: VAL_W]);
   end

   // ------------------------------------------------------------------------
   // Response side
   // ------------------------------------------------------------------------
   // The receiver stalls at random, with stretches where it stays ready.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else if (ready_calm > 0) begin
         ready_calm--;
         rsp_tready <= 1'b1;
      end else if ($urandom_range(0, 99) < 8) begin
         ready_calm = $urandom_range(20, 80);
         rsp_tready <= 1'b1;
      end else if ($urandom_range(0, 99) < 65) begin
         rsp_tready <= 1'b1;
      end else begin
         stall_left = idle_length();
         rsp_tready <= 1'b0;
      end
   end

   // Each accepted response is checked against the oldest awaited one.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (awaited_rsp.size() == 0) begin
            report_mismatch("response with none awaited", 64'(rsp_tdata), 64'(0));
         end else begin
            got_rsp = awaited_rsp.pop_front();
            if (rsp_tdata[ELEM_W-1:0] !== got_rsp.element)
               report_mismatch("element", 64'(rsp_tdata[ELEM_W-1:0]),
                               64'(got_rsp.element));
            if (rsp_tdata[ELEM_W +: LEN_W] !== got_rsp.length)
               report_mismatch("length", 64'(rsp_tdata[ELEM_W +: LEN_W]),
                               64'(got_rsp.length));
            if (rsp_tdata[RSP_TDATA_W-1:ELEM_W+LEN_W] !== '0)
               report_mismatch("pad bits", 64'(rsp_tdata[RSP_TDATA_W-1:ELEM_W+LEN_W]),
                               64'(0));
            if (rsp_tlast !== got_rsp.last)
               report_mismatch("done flag", 64'(rsp_tlast), 64'(got_rsp.last));
            if (rsp_tuser !== got_rsp.ok)
               report_mismatch("ok flag", 64'(rsp_tuser), 64'(got_rsp.ok));
         end
      end
   end

   // Watchdog: the run fails once the cycle count reaches CYCLE_LIMIT.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d responses still awaited",
                  cycle_count, awaited_rsp.size());
         $display("*** FAILED ***");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus and end of run
   // ------------------------------------------------------------------------
   initial begin
      int burst;

      // Directed part: empty-list cases first.
      queue_request(pil_pkg::FUNC_DUMP,   16'h0000, 32'h0);
      queue_request(pil_pkg::FUNC_REMOVE, 16'h0000, 32'h0);
      queue_request(pil_pkg::FUNC_INSERT, 16'h0000, 32'h1234_5678);   // no-op on empty
      queue_request(pil_pkg::FUNC_INSERT, 16'h8000, 32'hdead_beef);   // most negative: tail
      queue_request(pil_pkg::FUNC_REMOVE, 16'hffff, 32'hffff_ffff);   // back to empty
      queue_request(pil_pkg::FUNC_INSERT, 16'h0005, 32'h0000_0005);   // any position on empty
      queue_request(pil_pkg::FUNC_APPEND, 16'h0000, 32'h7fff_ffff);
      queue_request(pil_pkg::FUNC_APPEND, 16'hffff, 32'h8000_0000);
      queue_request(pil_pkg::FUNC_INSERT, 16'h0001, 32'h0000_0000);   // head
      queue_request(pil_pkg::FUNC_INSERT, 16'hfffe, 32'hffff_ffff);   // magnitude two
      queue_request(pil_pkg::FUNC_INSERT, 16'h7fff, 32'h5555_aaaa);   // past the count
      queue_request(pil_pkg::FUNC_INSERT, 16'h0003, 32'haaaa_5555);
      queue_request(pil_pkg::FUNC_DUMP,   16'h0000, 32'h0);
      queue_request(pil_pkg::FUNC_REMOVE, 16'h0000, 32'h0);
      queue_request(pil_pkg::FUNC_INSERT, 16'h0000, 32'h0bad_0bad);   // no-op on a list
      queue_request(pil_pkg::FUNC_DUMP,   16'hffff, 32'hffff_ffff);
      // Fill up, then try to grow a full list.
      while (plan_len < LIST_DEPTH)
         queue_request(pil_pkg::FUNC_APPEND, 16'h0, pick_value());
      queue_request(pil_pkg::FUNC_APPEND, 16'h0000, 32'h0101_0101);
      queue_request(pil_pkg::FUNC_INSERT, 16'h0001, 32'h0202_0202);
      queue_request(pil_pkg::FUNC_INSERT, 16'h0000, 32'h0303_0303);
      queue_request(pil_pkg::FUNC_DUMP,   16'h0000, 32'h0, 1'b1);     // after a full drain

      // Random part, in bursts that push the list to both ends.
      while (request_backlog.size() < TARGET_REQS) begin
         burst = $urandom_range(0, 3);
         case (burst)
            0: queue_fill_burst();
            1: queue_drain_burst();
            2: repeat ($urandom_range(5, 15)) queue_random_op();
            default: begin
               queue_random_op(1'b1);
               repeat ($urandom_range(2, 8)) queue_random_op();
            end
         endcase
         if ($urandom_range(0, 1))
            queue_request(pil_pkg::FUNC_DUMP, POS_W'($urandom()), $urandom());
      end

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      while (request_backlog.size() > 0 || req_tvalid || awaited_rsp.size() > 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && awaited_rsp.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
